[src/bitmap_font_glyph_expander_assert.svh]
// Assertion macros used by the glyph expander module.
`ifndef BITMAP_FONT_GLYPH_EXPANDER_ASSERT_SVH
`define BITMAP_FONT_GLYPH_EXPANDER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BFGE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bfge: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define BFGE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bfge: next-cycle check failed");

`endif

[src/bfge_pkg.sv]
// Types, constants and helper functions of the bitmap font glyph expander.
package bfge_pkg;

  localparam int FONT_SLOTS    = 96;
  localparam int GLYPH_COLUMNS = 5;
  localparam int GLYPH_ROWS    = 7;

  localparam int CODE_W   = 8;
  localparam int GCOL_W   = 3;
  localparam int BITS_W   = 7;
  localparam int COORD_W  = 12;
  localparam int SCALE_W  = 4;
  localparam int COLOR_W  = 16;

  localparam int FIRST_CODE = 32;
  localparam int END_CODE   = 128;

  localparam int STORE_DEPTH = FONT_SLOTS * GLYPH_COLUMNS;
  localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int COL_W  = (GLYPH_COLUMNS > 1) ? $clog2(GLYPH_COLUMNS) : 1;
  localparam int ROW_W  = (GLYPH_ROWS > 1) ? $clog2(GLYPH_ROWS) : 1;
  localparam int FCNT_W = $clog2(GLYPH_COLUMNS + 1);

  localparam int MAX_SCALE = (1 << SCALE_W) - 1;
  localparam int DIM_MAX   = (GLYPH_COLUMNS + 1 > GLYPH_ROWS) ? GLYPH_COLUMNS + 1 : GLYPH_ROWS;
  localparam int OFF_W     = $clog2(DIM_MAX * MAX_SCALE + 1);

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = COLOR_W;

  localparam logic [SCALE_W-1:0] SCALE_RST = SCALE_W'(1);
  localparam logic [COLOR_W-1:0] COLOR_RST = '1;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_DRAW = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_SCALE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FETCH,
    ST_SCAN
  } state_t;

  typedef struct packed {
    logic                  en;
    logic [ADDR_W-1:0]     addr;
    logic [GLYPH_ROWS-1:0] data;
  } font_wr_t;

  // Saturating coordinate add, clamps at the top of the coordinate range.
  function automatic logic [COORD_W-1:0] sat_add(input logic [COORD_W-1:0] a,
                                                 input logic [OFF_W-1:0] b);
    logic [COORD_W:0] s;
    s = {1'b0, a} + (COORD_W + 1)'(b);
    return s[COORD_W] ? {COORD_W{1'b1}} : s[COORD_W-1:0];
  endfunction

  // Fit the loaded column bits to the row count of the store.
  function automatic logic [GLYPH_ROWS-1:0] row_bits(input logic [BITS_W-1:0] b);
    logic [GLYPH_ROWS-1:0] r;
    r = '0;
    for (int i = 0; i < GLYPH_ROWS; i++) begin
      if (i < BITS_W) r[i] = b[i];
    end
    return r;
  endfunction

endpackage

[src/bfge_if.sv]
// Valid/ready channel interfaces for the glyph expander input and result beats.
interface bfge_in_if;
  logic                            valid;
  logic                            ready;
  logic                            func;
  logic [bfge_pkg::CODE_W-1:0]     char_code;
  logic [bfge_pkg::GCOL_W-1:0]     glyph_column;
  logic [bfge_pkg::BITS_W-1:0]     column_bits;
  logic                            start_flag;
  logic [bfge_pkg::COORD_W-1:0]    origin_x;
  logic [bfge_pkg::COORD_W-1:0]    origin_y;

  modport source (output valid, func, char_code, glyph_column, column_bits, start_flag,
                  origin_x, origin_y, input ready);
  modport sink   (input valid, func, char_code, glyph_column, column_bits, start_flag,
                  origin_x, origin_y, output ready);
endinterface

interface bfge_out_if;
  logic                            valid;
  logic                            ready;
  logic [bfge_pkg::COORD_W-1:0]    block_x;
  logic [bfge_pkg::COORD_W-1:0]    block_y;
  logic [bfge_pkg::SCALE_W-1:0]    block_size;
  logic [bfge_pkg::COLOR_W-1:0]    block_color;
  logic                            last_block;

  modport source (output valid, block_x, block_y, block_size, block_color, last_block,
                  input ready);
  modport sink   (input valid, block_x, block_y, block_size, block_color, last_block,
                  output ready);
endinterface

[src/bfge_font_mem.sv]
// Font store memory with a zero-fill sweep after reset.
module bfge_font_mem (
  input  logic                              clk,
  input  logic                              rst_n,
  input  bfge_pkg::font_wr_t                wr,
  input  logic                              rd_en,
  input  logic [bfge_pkg::ADDR_W-1:0]       rd_addr,
  output logic [bfge_pkg::GLYPH_ROWS-1:0]   rd_data,
  output logic                              busy
);

  logic [bfge_pkg::GLYPH_ROWS-1:0] mem [bfge_pkg::STORE_DEPTH];
  logic [bfge_pkg::GLYPH_ROWS-1:0] rd_data_r;
  logic [bfge_pkg::ADDR_W-1:0]     clr_addr_r, clr_addr_nxt;
  logic                            busy_r, busy_nxt;

  always_comb begin
    clr_addr_nxt = clr_addr_r;
    busy_nxt     = busy_r;
    if (busy_r) begin
      clr_addr_nxt = clr_addr_r + 1'b1;
      if (clr_addr_r == bfge_pkg::ADDR_W'(bfge_pkg::STORE_DEPTH - 1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
      busy_r     <= 1'b1;
    end else begin
      clr_addr_r <= clr_addr_nxt;
      busy_r     <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      mem[clr_addr_r] <= '0;
    end else if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;
  assign busy    = busy_r;

endmodule

[src/bitmap_font_glyph_expander.sv]
// Bitmap font glyph expander: turns characters into scaled pixel blocks.
//
// in_chan carries load beats (func 0: write one glyph column into the font
// store) and draw beats (func 1: expand one character). out_chan carries one
// beat per set font dot: block origin, size, color and a last flag on the final
// block of the character. cfg_we/cfg_addr/cfg_data write glyph_scale (index 0)
// and text_color (index 1); write them only while the block is idle.
// A load beat leaves the block idle. A draw beat reads the five glyph columns
// from the font memory's read port (ST_FETCH), then scans one dot position per
// cycle, stalling as below (up to 35 positions), and advances the cursor in the
// final ST_SCAN step. Dot positions after the last set bit are skipped. A blank
// glyph skips the scan; a zero scale leaves the block idle and draws nothing.
// After reset the font store is zero-filled, one entry a cycle: in_chan stays
// not ready until the fill is done. Cursor resets to 0,0,
// scale to 1, color to white.
// Results sit in an output register that reloads in the cycle its beat is
// taken; the scan stalls on a set dot only while that register is full and
// out_chan is not ready.
module bitmap_font_glyph_expander (
  input  logic                                   clk,
  input  logic                                   rst_n,
  bfge_in_if.sink                                in_chan,
  bfge_out_if.source                             out_chan,
  input  logic                                   cfg_we,
  input  logic [bfge_pkg::CFG_IDX_W-1:0]         cfg_addr,
  input  logic [bfge_pkg::CFG_DATA_W-1:0]        cfg_data
);

  bfge_pkg::state_t state_r, state_nxt;

  logic [bfge_pkg::SCALE_W-1:0] scale_r;
  logic [bfge_pkg::COLOR_W-1:0] color_r;

  logic [bfge_pkg::COORD_W-1:0] cursor_x_r, cursor_x_nxt;
  logic [bfge_pkg::COORD_W-1:0] cursor_y_r, cursor_y_nxt;
  logic [bfge_pkg::ADDR_W-1:0]  base_r, base_nxt;
  logic [bfge_pkg::FCNT_W-1:0]  fcnt_r, fcnt_nxt;
  logic [bfge_pkg::COL_W-1:0]   col_r, col_nxt;
  logic [bfge_pkg::ROW_W-1:0]   row_r, row_nxt;
  logic [bfge_pkg::OFF_W-1:0]   x_off_r, x_off_nxt;
  logic [bfge_pkg::OFF_W-1:0]   y_off_r, y_off_nxt;

  logic [bfge_pkg::GLYPH_COLUMNS-1:0][bfge_pkg::GLYPH_ROWS-1:0] glyph_r, glyph_nxt, glyph_rem;

  logic                         out_valid_r, out_valid_nxt;
  logic [bfge_pkg::COORD_W-1:0] blk_x_r, blk_y_r;
  logic [bfge_pkg::SCALE_W-1:0] blk_size_r;
  logic [bfge_pkg::COLOR_W-1:0] blk_color_r;
  logic                         blk_last_r;

  bfge_pkg::font_wr_t              mem_wr;
  logic                            mem_rd_en;
  logic [bfge_pkg::ADDR_W-1:0]     mem_rd_addr;
  logic [bfge_pkg::GLYPH_ROWS-1:0] mem_rd_data;
  logic                            mem_busy;

  logic                            in_acc;
  logic                            draw_go, scan_done;
  logic                            cur_bit, glyph_empty, out_free, out_load, step, last;
  logic [bfge_pkg::CODE_W-1:0]     slot;
  logic [bfge_pkg::OFF_W-1:0]      adv;

  bfge_font_mem u_font_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (mem_wr),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .busy    (mem_busy)
  );

  assign in_chan.ready = (state_r == bfge_pkg::ST_IDLE);
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign draw_go       = in_acc && in_chan.func == bfge_pkg::FUNC_DRAW && scale_r != '0;

  assign cur_bit     = glyph_r[col_r][row_r];
  assign glyph_empty = (glyph_r == '0);
  assign scan_done   = (state_r == bfge_pkg::ST_SCAN) && glyph_empty;
  assign out_free    = !out_valid_r || out_chan.ready;
  assign out_load    = (state_r == bfge_pkg::ST_SCAN) && !glyph_empty && cur_bit && out_free;
  assign step        = (state_r == bfge_pkg::ST_SCAN) && !glyph_empty &&
                       (!cur_bit || out_free);

  always_comb begin
    glyph_rem               = glyph_r;
    glyph_rem[col_r][row_r] = 1'b0;
  end
  assign last = (glyph_rem == '0);

  assign adv = bfge_pkg::OFF_W'(bfge_pkg::GLYPH_COLUMNS + 1) * bfge_pkg::OFF_W'(scale_r);

  // Codes outside the printable range, or past the store, fall back to slot 0.
  always_comb begin
    slot = '0;
    if (in_chan.char_code >= bfge_pkg::CODE_W'(bfge_pkg::FIRST_CODE) &&
        {1'b0, in_chan.char_code} < (bfge_pkg::CODE_W + 1)'(bfge_pkg::END_CODE)) begin
      slot = in_chan.char_code - bfge_pkg::CODE_W'(bfge_pkg::FIRST_CODE);
      if ({1'b0, slot} >= (bfge_pkg::CODE_W + 1)'(bfge_pkg::FONT_SLOTS)) slot = '0;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bfge_pkg::ST_CLEAR: if (!mem_busy) state_nxt = bfge_pkg::ST_IDLE;
      bfge_pkg::ST_IDLE: begin
        if (draw_go) state_nxt = bfge_pkg::ST_FETCH;
      end
      bfge_pkg::ST_FETCH: begin
        if (fcnt_r == bfge_pkg::FCNT_W'(bfge_pkg::GLYPH_COLUMNS)) state_nxt = bfge_pkg::ST_SCAN;
      end
      bfge_pkg::ST_SCAN: if (scan_done) state_nxt = bfge_pkg::ST_IDLE;
      default: state_nxt = bfge_pkg::ST_IDLE;
    endcase
  end

  // Memory port controls
  always_comb begin
    mem_wr.en   = in_acc && in_chan.func == bfge_pkg::FUNC_LOAD &&
                  {1'b0, in_chan.char_code} < (bfge_pkg::CODE_W + 1)'(bfge_pkg::FONT_SLOTS) &&
                  {2'b00, in_chan.glyph_column} < (bfge_pkg::GCOL_W + 2)'(bfge_pkg::GLYPH_COLUMNS);
    mem_wr.addr = bfge_pkg::ADDR_W'(in_chan.char_code) *
                  bfge_pkg::ADDR_W'(bfge_pkg::GLYPH_COLUMNS) +
                  bfge_pkg::ADDR_W'(in_chan.glyph_column);
    mem_wr.data = bfge_pkg::row_bits(in_chan.column_bits);
    mem_rd_en   = (state_r == bfge_pkg::ST_FETCH) &&
                  (fcnt_r < bfge_pkg::FCNT_W'(bfge_pkg::GLYPH_COLUMNS));
    mem_rd_addr = base_r + bfge_pkg::ADDR_W'(fcnt_r);
  end

  // Datapath next values
  always_comb begin
    cursor_x_nxt = cursor_x_r;
    cursor_y_nxt = cursor_y_r;
    base_nxt     = base_r;
    fcnt_nxt     = fcnt_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    x_off_nxt    = x_off_r;
    y_off_nxt    = y_off_r;
    glyph_nxt    = glyph_r;

    if (in_acc && in_chan.func == bfge_pkg::FUNC_DRAW) begin
      if (in_chan.start_flag) begin
        cursor_x_nxt = in_chan.origin_x;
        cursor_y_nxt = in_chan.origin_y;
      end
      base_nxt  = bfge_pkg::ADDR_W'(slot) * bfge_pkg::ADDR_W'(bfge_pkg::GLYPH_COLUMNS);
      fcnt_nxt  = '0;
      col_nxt   = '0;
      row_nxt   = '0;
      x_off_nxt = '0;
      y_off_nxt = '0;
    end

    if (state_r == bfge_pkg::ST_FETCH) begin
      fcnt_nxt = fcnt_r + 1'b1;
      // read data is registered in the memory, so it belongs to the previous fcnt
      if (fcnt_r != '0) glyph_nxt[bfge_pkg::COL_W'(fcnt_r - 1'b1)] = mem_rd_data;
    end

    if (scan_done) begin
      cursor_x_nxt = bfge_pkg::sat_add(cursor_x_r, adv);
    end

    if (step) begin
      if (cur_bit) glyph_nxt = glyph_rem;
      if (row_r == bfge_pkg::ROW_W'(bfge_pkg::GLYPH_ROWS - 1)) begin
        row_nxt   = '0;
        y_off_nxt = '0;
        if (col_r != bfge_pkg::COL_W'(bfge_pkg::GLYPH_COLUMNS - 1)) begin
          col_nxt   = col_r + 1'b1;
          x_off_nxt = x_off_r + bfge_pkg::OFF_W'(scale_r);
        end
      end else begin
        row_nxt   = row_r + 1'b1;
        y_off_nxt = y_off_r + bfge_pkg::OFF_W'(scale_r);
      end
    end
  end

  assign out_valid_nxt = out_load || (out_valid_r && !out_chan.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bfge_pkg::ST_CLEAR;
      scale_r     <= bfge_pkg::SCALE_RST;
      color_r     <= bfge_pkg::COLOR_RST;
      cursor_x_r  <= '0;
      cursor_y_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cursor_x_r  <= cursor_x_nxt;
      cursor_y_r  <= cursor_y_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          bfge_pkg::CFG_SCALE: scale_r <= cfg_data[bfge_pkg::SCALE_W-1:0];
          bfge_pkg::CFG_COLOR: color_r <= cfg_data[bfge_pkg::COLOR_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    base_r  <= base_nxt;
    fcnt_r  <= fcnt_nxt;
    col_r   <= col_nxt;
    row_r   <= row_nxt;
    x_off_r <= x_off_nxt;
    y_off_r <= y_off_nxt;
    glyph_r <= glyph_nxt;
    if (out_load) begin
      blk_x_r     <= bfge_pkg::sat_add(cursor_x_r, x_off_r);
      blk_y_r     <= bfge_pkg::sat_add(cursor_y_r, y_off_r);
      blk_size_r  <= scale_r;
      blk_color_r <= color_r;
      blk_last_r  <= last;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.block_x     = blk_x_r;
  assign out_chan.block_y     = blk_y_r;
  assign out_chan.block_size  = blk_size_r;
  assign out_chan.block_color = blk_color_r;
  assign out_chan.last_block  = blk_last_r;

`include "bitmap_font_glyph_expander_assert.svh"

  `BFGE_ASSERT_NOW(a_clear_blocks_input, mem_busy, !in_chan.ready)
  `BFGE_ASSERT_NEXT(a_last_empties_glyph, out_load && last, glyph_r == '0)
  `BFGE_ASSERT_NEXT(a_empty_scan_idles, scan_done, state_r == bfge_pkg::ST_IDLE)
  `BFGE_ASSERT_NEXT(a_draw_starts_fetch, draw_go, state_r == bfge_pkg::ST_FETCH && fcnt_r == '0)

endmodule
